// ===== rtl/imudr_pkg.sv =====
`timescale 1ns / 1ps

package imudr_pkg;

    localparam logic [15:0] TS_RESET = 16'd6554;
    localparam logic [15:0] BW_RESET = 16'd64225;

    localparam logic [7:0] REG_TIME_STEP    = 8'd0;
    localparam logic [7:0] REG_BLEND_WEIGHT = 8'd1;

    // pi and 2*pi in q16.16, one guard bit
    localparam logic signed [32:0] PI_Q16     = 33'sd205887;
    localparam logic signed [32:0] TWO_PI_Q16 = 33'sd411775;

    // one strobe per step of the item sequence
    typedef struct packed {
        logic load;
        logic vel_upd;
        logic pos_mul;
        logic pos_upd;
        logic fin;
    } step_ctl_t;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic [2:0] top;
        top = v[33:31];
        if (top == 3'b000 || top == 3'b111)
        begin
            return v[31:0];
        end
        else if (v[33])
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

// ===== rtl/imudr_sample_if.sv =====
`timescale 1ns / 1ps

interface imudr_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] heading;

    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    heading, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  heading, output ready);
endinterface

// ===== rtl/imudr_result_if.sv =====
`timescale 1ns / 1ps

interface imudr_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] yaw_angle;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// ===== rtl/imudr_cfg_if.sv =====
`timescale 1ns / 1ps

interface imudr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/imudr_trans_lane.sv =====
`timescale 1ns / 1ps

module imudr_trans_lane (
    input  logic                     clk,
    input  logic                     rst_n,
    input  imudr_pkg::step_ctl_t     ctl,
    input  logic [15:0]              time_step,
    input  logic signed [15:0]       accel,
    output logic signed [31:0]       vel,
    output logic signed [31:0]       pos
);

    logic signed [16:0] ts_s;
    logic signed [32:0] aprod_reg;
    logic signed [48:0] vprod_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] vel_next;
    logic signed [31:0] pos_next;

    assign ts_s = $signed({1'b0, time_step});

    // q8.24 increment floored to q16.16, then the q16.16 velocity step floored
    assign vel_next = imudr_pkg::sat34($signed({{2{vel_reg[31]}}, vel_reg}
                      + {{9{aprod_reg[32]}}, aprod_reg[32:8]}));
    assign pos_next = imudr_pkg::sat34($signed({{2{pos_reg[31]}}, pos_reg}
                      + {vprod_reg[48], vprod_reg[48:16]}));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            aprod_reg <= accel * ts_s;
        end
        if (ctl.pos_mul)
        begin
            vprod_reg <= vel_reg * ts_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            if (ctl.vel_upd)
            begin
                vel_reg <= vel_next;
            end
            if (ctl.pos_upd)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    assign vel = vel_reg;
    assign pos = pos_reg;

endmodule

// ===== rtl/imudr_ang_lane.sv =====
`timescale 1ns / 1ps

module imudr_ang_lane (
    input  logic                     clk,
    input  logic                     rst_n,
    input  imudr_pkg::step_ctl_t     ctl,
    input  logic [15:0]              time_step,
    input  logic signed [15:0]       rate,
    input  logic                     wb_en,
    input  logic signed [31:0]       wb_angle,
    output logic signed [31:0]       angle
);

    logic signed [32:0] rprod_reg;
    logic signed [31:0] angle_reg;
    logic signed [31:0] angle_next;

    assign angle_next = imudr_pkg::sat34($signed({{2{angle_reg[31]}}, angle_reg}
                        + {{9{rprod_reg[32]}}, rprod_reg[32:8]}));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rprod_reg <= rate * $signed({1'b0, time_step});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
        end
        else if (ctl.fin && wb_en)
        begin
            angle_reg <= wb_angle;
        end
        else if (ctl.vel_upd)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// ===== rtl/imudr_yaw_merge.sv =====
`timescale 1ns / 1ps

module imudr_yaw_merge (
    input  logic                     clk,
    input  imudr_pkg::step_ctl_t     ctl,
    input  logic [15:0]              blend_weight,
    input  logic signed [15:0]       heading,
    input  logic signed [31:0]       yaw_int,
    output logic signed [31:0]       yaw_fused
);

    logic signed [17:0] heading_w;
    logic signed [33:0] hprod_reg;
    logic signed [48:0] yprod_reg;
    logic signed [31:0] blend_reg;
    logic signed [32:0] b33;
    logic signed [32:0] wrap_hi;
    logic signed [32:0] wrap_lo;

    // weight left for the heading, 1 .. 65536
    assign heading_w = $signed({1'b0, 17'd65536 - {1'b0, blend_weight}});

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            hprod_reg <= heading_w * heading;
        end
        if (ctl.pos_mul)
        begin
            yprod_reg <= yaw_int * $signed({1'b0, blend_weight});
        end
        if (ctl.pos_upd)
        begin
            blend_reg <= imudr_pkg::sat34($signed({yprod_reg[48], yprod_reg[48:16]}
                         + {{8{hprod_reg[33]}}, hprod_reg[33:8]}));
        end
    end

    // single wrap step each way
    always_comb
    begin
        b33 = $signed({blend_reg[31], blend_reg});
        wrap_hi = (b33 > imudr_pkg::PI_Q16) ? b33 - imudr_pkg::TWO_PI_Q16 : b33;
        wrap_lo = (wrap_hi < -imudr_pkg::PI_Q16) ? wrap_hi + imudr_pkg::TWO_PI_Q16
                                                 : wrap_hi;
    end

    assign yaw_fused = wrap_lo[31:0];

endmodule

// ===== rtl/imu_dead_reckoning_fuser_top.sv =====
`timescale 1ns / 1ps

// Dead reckoning with a complementary filter on yaw. Each sample item carries
// q8.8 acceleration, angular rate and magnetometer heading; the block keeps
// velocity, position and roll/pitch/yaw in q16.16 with saturating sums and
// returns one result item per sample holding the updated state. Three
// translational lanes and three angular lanes work side by side, and a yaw
// merge stage blends the integrated yaw with the heading and wraps it once
// towards [-pi, pi]. From acceptance to its result an item passes through
// the velocity step, the velocity-times-step multiply, the position add and
// the final wrap, one after another; the result is loaded once the result
// side is free, and the next item is taken the cycle after that, so only
// one item is in flight. Config register 0 is the time step, 1 the blend
// weight, both unsigned q0.16; write them only while the block is idle.
module imu_dead_reckoning_fuser_top (
    input  logic    clk,
    input  logic    rst_n,
    imudr_sample_if.sink   sample,
    imudr_result_if.source result,
    imudr_cfg_if.sink      cfg
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_VEL,
        PH_PMUL,
        PH_POS,
        PH_FIN
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;

    logic [15:0] ts_reg;
    logic [15:0] bw_reg;

    imudr_pkg::step_ctl_t ctl;
    logic out_free;

    logic signed [31:0] vel_x, vel_y, vel_z;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] roll, pitch, yaw_int, yaw_fused;

    logic               out_valid_reg;
    logic signed [31:0] out_pos_x_reg, out_pos_y_reg, out_pos_z_reg;
    logic signed [31:0] out_vel_x_reg, out_vel_y_reg, out_vel_z_reg;
    logic signed [31:0] out_roll_reg, out_pitch_reg, out_yaw_reg;

    assign out_free     = !out_valid_reg || result.ready;
    assign sample.ready = (phase_reg == PH_IDLE);
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        ctl.load    = sample.valid && (phase_reg == PH_IDLE);
        ctl.vel_upd = (phase_reg == PH_VEL);
        ctl.pos_mul = (phase_reg == PH_PMUL);
        ctl.pos_upd = (phase_reg == PH_POS);
        ctl.fin     = (phase_reg == PH_FIN) && out_free;
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: if (ctl.load) phase_next = PH_VEL;
            PH_VEL:  phase_next = PH_PMUL;
            PH_PMUL: phase_next = PH_POS;
            PH_POS:  phase_next = PH_FIN;
            PH_FIN:  if (ctl.fin) phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
            out_pos_x_reg <= '0;
            out_pos_y_reg <= '0;
            out_pos_z_reg <= '0;
            out_vel_x_reg <= '0;
            out_vel_y_reg <= '0;
            out_vel_z_reg <= '0;
            out_roll_reg  <= '0;
            out_pitch_reg <= '0;
            out_yaw_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (ctl.fin)
            begin
                out_valid_reg <= 1'b1;
                out_pos_x_reg <= pos_x;
                out_pos_y_reg <= pos_y;
                out_pos_z_reg <= pos_z;
                out_vel_x_reg <= vel_x;
                out_vel_y_reg <= vel_y;
                out_vel_z_reg <= vel_z;
                out_roll_reg  <= roll;
                out_pitch_reg <= pitch;
                out_yaw_reg   <= yaw_fused;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= imudr_pkg::TS_RESET;
            bw_reg <= imudr_pkg::BW_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                imudr_pkg::REG_TIME_STEP:    ts_reg <= cfg.data;
                imudr_pkg::REG_BLEND_WEIGHT: bw_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    imudr_trans_lane u_lane_x (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .time_step(ts_reg),
        .accel(sample.accel_x), .vel(vel_x), .pos(pos_x)
    );

    imudr_trans_lane u_lane_y (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .time_step(ts_reg),
        .accel(sample.accel_y), .vel(vel_y), .pos(pos_y)
    );

    imudr_trans_lane u_lane_z (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .time_step(ts_reg),
        .accel(sample.accel_z), .vel(vel_z), .pos(pos_z)
    );

    imudr_ang_lane u_lane_roll (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .time_step(ts_reg),
        .rate(sample.rate_x), .wb_en(1'b0), .wb_angle(yaw_fused), .angle(roll)
    );

    imudr_ang_lane u_lane_pitch (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .time_step(ts_reg),
        .rate(sample.rate_y), .wb_en(1'b0), .wb_angle(yaw_fused), .angle(pitch)
    );

    // yaw lane takes the fused value back at the end of the item
    imudr_ang_lane u_lane_yaw (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .time_step(ts_reg),
        .rate(sample.rate_z), .wb_en(1'b1), .wb_angle(yaw_fused), .angle(yaw_int)
    );

    imudr_yaw_merge u_merge (
        .clk(clk), .ctl(ctl), .blend_weight(bw_reg), .heading(sample.heading),
        .yaw_int(yaw_int), .yaw_fused(yaw_fused)
    );

    assign result.valid       = out_valid_reg;
    assign result.pos_x       = out_pos_x_reg;
    assign result.pos_y       = out_pos_y_reg;
    assign result.pos_z       = out_pos_z_reg;
    assign result.vel_x       = out_vel_x_reg;
    assign result.vel_y       = out_vel_y_reg;
    assign result.vel_z       = out_vel_z_reg;
    assign result.roll_angle  = out_roll_reg;
    assign result.pitch_angle = out_pitch_reg;
    assign result.yaw_angle   = out_yaw_reg;

endmodule

// ===== rtl/imudr_checker.sv =====
`timescale 1ns / 1ps

module imudr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_yaw
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // one item in flight: no accept right after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_acc)
        else $error("second item accepted while one in flight");

    // a fresh result only comes out of a busy block
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item in flight");

    // no result shows too early after an accept made while none is out
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !out_valid |=> !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("result came too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_yaw))
        else $error("stalled result changed");

endmodule

bind imu_dead_reckoning_fuser_top imudr_checker u_imudr_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(sample.valid),
    .in_ready(sample.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .out_yaw(result.yaw_angle)
);

// ===== test/imu_dead_reckoning_fuser_top_test.sv =====
`timescale 1ns / 1ps

module imu_dead_reckoning_fuser_top_test;

    localparam logic [15:0] Q88_MAX         = 16'h7FFF;
    localparam logic [15:0] Q88_MIN         = 16'h8000;
    localparam int          HEADING_PI_Q88  = 804;
    localparam longint      ONE_Q16         = 65536;
    localparam logic [7:0]  FIRST_SPARE_REG = imudr_pkg::REG_BLEND_WEIGHT + 8'd1;
    localparam int          SETTLE_CYCLES   = 8;

    typedef struct packed {
        logic [2:0][15:0] accel;
        logic [2:0][15:0] rate;
        logic [15:0]      heading;
    } imu_sample_t;

    // pos x/y/z, vel x/y/z, roll, pitch, yaw
    typedef logic [0:8][31:0] pose_vec_t;

    logic clk = 1'b0;
    logic rst_n;

    imudr_sample_if sample_ch();
    imudr_result_if result_ch();
    imudr_cfg_if    cfg_ch();

    imu_dead_reckoning_fuser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #6 clk = ~clk;

    imu_sample_t samples_to_send [$];
    pose_vec_t   predicted_poses [$];
    imu_sample_t on_bus;
    int          mismatches = 0;
    bit          no_stall = 1'b0;
    bit          drift_up [6];

    string field_label [0:8] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                                 "roll_angle", "pitch_angle", "yaw_angle"};

    // predictor copy of the block state and registers
    logic signed [31:0] vel_q [3];
    logic signed [31:0] pos_q [3];
    logic signed [31:0] ang_q [3];
    logic [15:0]        step_q = imudr_pkg::TS_RESET;
    logic [15:0]        weight_q = imudr_pkg::BW_RESET;

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            vel_q[i] = '0;
            pos_q[i] = '0;
            ang_q[i] = '0;
        end
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < longint'(32'sh8000_0000))
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // q8.8 input times q0.16 step gives q8.24, floored down to q16.16
    function automatic longint scale_q88(input logic [15:0] x);
        return (longint'($signed(x)) * longint'(step_q)) >>> 8;
    endfunction

    function automatic pose_vec_t advance_pose(input imu_sample_t s);
        longint y;
        int     i;
        for (i = 0; i < 3; i++)
        begin
            vel_q[i] = clamp32(longint'(vel_q[i]) + scale_q88(s.accel[i]));
        end
        for (i = 0; i < 3; i++)
        begin
            pos_q[i] = clamp32(longint'(pos_q[i])
                               + ((longint'(vel_q[i]) * longint'(step_q)) >>> 16));
        end
        for (i = 0; i < 3; i++)
        begin
            ang_q[i] = clamp32(longint'(ang_q[i]) + scale_q88(s.rate[i]));
        end
        y = ((longint'(ang_q[2]) * longint'(weight_q)) >>> 16)
            + (((ONE_Q16 - longint'(weight_q)) * longint'($signed(s.heading))) >>> 8);
        y = clamp32(y);
        // single wrap each way, far-out yaw stays out
        if (y > longint'(imudr_pkg::PI_Q16))
        begin
            y = y - longint'(imudr_pkg::TWO_PI_Q16);
        end
        if (y < -longint'(imudr_pkg::PI_Q16))
        begin
            y = y + longint'(imudr_pkg::TWO_PI_Q16);
        end
        ang_q[2] = y[31:0];
        return {pos_q[0], pos_q[1], pos_q[2], vel_q[0], vel_q[1], vel_q[2],
                ang_q[0], ang_q[1], ang_q[2]};
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                predicted_poses.push_back(advance_pose(on_bus));
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (samples_to_send.size() > 0 && (no_stall || $urandom_range(0, 99) >= 16))
                begin
                    on_bus = samples_to_send.pop_front();
                    sample_ch.valid   <= 1'b1;
                    sample_ch.accel_x <= on_bus.accel[0];
                    sample_ch.accel_y <= on_bus.accel[1];
                    sample_ch.accel_z <= on_bus.accel[2];
                    sample_ch.rate_x  <= on_bus.rate[0];
                    sample_ch.rate_y  <= on_bus.rate[1];
                    sample_ch.rate_z  <= on_bus.rate[2];
                    sample_ch.heading <= on_bus.heading;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        pose_vec_t got;
        pose_vec_t want;
        int        k;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = {result_ch.pos_x, result_ch.pos_y, result_ch.pos_z,
                       result_ch.vel_x, result_ch.vel_y, result_ch.vel_z,
                       result_ch.roll_angle, result_ch.pitch_angle, result_ch.yaw_angle};
                if (predicted_poses.size() == 0)
                begin
                    $display("%0t: result item with none expected, yaw_angle got %0d",
                             $time, $signed(got[8]));
                    mismatches++;
                end
                else
                begin
                    want = predicted_poses.pop_front();
                    for (k = 0; k < 9; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            $display("%0t: %s expected %0d got %0d", $time, field_label[k],
                                     $signed(want[k]), $signed(got[k]));
                            mismatches++;
                        end
                    end
                end
            end
            result_ch.ready <= no_stall || ($urandom_range(0, 99) >= 16);
        end
    end

    task automatic queue_sample(input logic [15:0] ax, input logic [15:0] ay,
                                input logic [15:0] az, input logic [15:0] rx,
                                input logic [15:0] ry, input logic [15:0] rz,
                                input logic [15:0] hd);
        imu_sample_t s;
        s.accel[0] = ax;
        s.accel[1] = ay;
        s.accel[2] = az;
        s.rate[0]  = rx;
        s.rate[1]  = ry;
        s.rate[2]  = rz;
        s.heading  = hd;
        samples_to_send.push_back(s);
    endtask

    // long same-sign runs half the time so the sums saturate, else noise or extremes
    function automatic logic [15:0] pick_lane(input int lane);
        logic [15:0] v;
        if ($urandom_range(0, 127) == 0)
        begin
            drift_up[lane] = !drift_up[lane];
        end
        case ($urandom_range(0, 7))
            0, 1:
            begin
                v = 16'($urandom);
            end
            2:
            begin
                v = $urandom_range(0, 1) ? Q88_MAX : Q88_MIN;
            end
            3:
            begin
                v = 16'($urandom_range(0, 511) - 256);
            end
            default:
            begin
                v = drift_up[lane] ? 16'($urandom_range(16384, 32767))
                                   : 16'(0 - $urandom_range(16384, 32768));
            end
        endcase
        return v;
    endfunction

    task automatic queue_random(input int count);
        logic [15:0] hd;
        for (int n = 0; n < count; n++)
        begin
            hd = $urandom_range(0, 1) ? 16'($urandom)
                                      : 16'(HEADING_PI_Q88 - $urandom_range(0, 2 * HEADING_PI_Q88));
            queue_sample(pick_lane(0), pick_lane(1), pick_lane(2),
                         pick_lane(3), pick_lane(4), pick_lane(5), hd);
        end
    endtask

    // wait for every item to come back, then let the pipeline settle;
    // checked away from the rising edge so the driver's updates have landed
    task automatic drain();
        while (samples_to_send.size() > 0 || sample_ch.valid || predicted_poses.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [7:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == imudr_pkg::REG_TIME_STEP)
        begin
            step_q = val;
        end
        else if (idx == imudr_pkg::REG_BLEND_WEIGHT)
        begin
            weight_q = val;
        end
    endtask

    task automatic set_filter(input logic [15:0] ts, input logic [15:0] bw);
        write_register(imudr_pkg::REG_TIME_STEP, ts);
        write_register(imudr_pkg::REG_BLEND_WEIGHT, bw);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.rate_x  = '0;
        sample_ch.rate_y  = '0;
        sample_ch.rate_z  = '0;
        sample_ch.heading = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, register defaults
        queue_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        queue_sample(Q88_MAX, Q88_MAX, Q88_MAX, Q88_MAX, Q88_MAX, Q88_MAX, Q88_MAX);
        queue_sample(Q88_MIN, Q88_MIN, Q88_MIN, Q88_MIN, Q88_MIN, Q88_MIN, Q88_MIN);
        queue_sample(Q88_MAX, Q88_MIN, 16'h0001, Q88_MIN, Q88_MAX, 16'hFFFF, Q88_MAX);
        queue_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, Q88_MIN);
        // yaw driven far past pi, one wrap cannot bring it back
        repeat (3) queue_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, Q88_MAX, 16'h0);
        repeat (3) queue_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, Q88_MIN, 16'h0);
        // steady turn that crosses pi and wraps back inside
        repeat (8) queue_sample(16'h0100, 16'hFF00, 16'h0, 16'h0, 16'h0, 16'sd1500, 16'sd800);
        drain();

        // zero step: only the yaw blend and wrap move
        write_register(imudr_pkg::REG_TIME_STEP, 16'h0);
        queue_sample(Q88_MAX, Q88_MIN, Q88_MAX, Q88_MAX, Q88_MIN, Q88_MAX, 16'sd700);
        queue_sample(Q88_MIN, Q88_MAX, Q88_MIN, Q88_MIN, Q88_MAX, Q88_MIN, Q88_MIN);
        drain();

        // zero weight: yaw follows the heading alone
        write_register(imudr_pkg::REG_BLEND_WEIGHT, 16'h0);
        queue_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd300);
        queue_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, Q88_MAX);
        queue_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, Q88_MIN);
        drain();

        // writes to unused indexes must leave the filter alone
        write_register(8'($urandom_range(FIRST_SPARE_REG, 255)), 16'($urandom));
        write_register(8'hFF, 16'hFFFF);
        queue_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd200);
        drain();

        set_filter(imudr_pkg::TS_RESET, imudr_pkg::BW_RESET);
        queue_random(350);
        drain();

        // long stretch without any idling on either side
        no_stall = 1'b1;
        set_filter(16'hFFFF, 16'hFFFF);
        queue_random(400);
        drain();
        no_stall = 1'b0;

        set_filter(16'h0001, 16'h0000);
        queue_random(300);
        drain();

        set_filter(16'($urandom_range(1, 65535)), 16'($urandom));
        queue_random(350);
        drain();

        set_filter(16'hFFFF, 16'h0000);
        queue_random(350);
        drain();

        if (mismatches == 0)
        begin
            $display("imu_dead_reckoning_fuser_top: match");
        end
        else
        begin
            $display("imu_dead_reckoning_fuser_top: mismatch");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("imu_dead_reckoning_fuser_top: mismatch");
        $finish;
    end

endmodule
